// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the priority queue RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define SPQ_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("spq assertion failed");

// antecedent in one cycle implies consequent in the next
`define SPQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`else

`define SPQ_ASSERT(name, clk, rst, prop)
`define SPQ_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared opcodes, status codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // request opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // response status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for queue requests and queue responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if #(
  parameter int PAYLOAD_BITS = 16,
  parameter int PRIO_BITS    = 4
);
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [PRIO_BITS-1:0]    prio;

  modport source (output valid, output opcode, output payload, output prio, input ready);
  modport sink   (input valid, input opcode, input payload, input prio, output ready);
endinterface

interface spq_rsp_if #(
  parameter int PAYLOAD_BITS = 16,
  parameter int PRIO_BITS    = 4,
  parameter int OCC_BITS     = 5
);
  logic                    valid;
  logic                    ready;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [PRIO_BITS-1:0]    out_prio;
  spq_pkg::status_t        status;
  logic [OCC_BITS-1:0]     occupancy;

  modport source (output valid, output out_payload, output out_prio, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input out_payload, input out_prio, input status,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/spq_step_unit.sv -----
// ----------------------------------------------------------------------------
// spq_step_unit
// Shared compare and ring-pointer step unit used by the queue sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_step_unit #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 4
) (
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] back_ptr,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] fwd_ptr,
  input  wire logic [PRIO_BITS-1:0]                    held_prio,
  input  wire logic [PRIO_BITS-1:0]                    new_prio,
  output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] prev_ptr,
  output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] next_ptr,
  output logic                                         moves
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  // ring decrement and increment
  assign prev_ptr = (back_ptr == '0) ? LAST : back_ptr - PTR_W'(1);
  assign next_ptr = (fwd_ptr == LAST) ? '0 : fwd_ptr + PTR_W'(1);

  // stored entry yields its place when its priority is not greater
  assign moves = (held_prio <= new_prio);

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept in descending priority order in a ring RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per operation: opcode enqueue (payload, prio) or
//   dequeue. Every request beat gives exactly one rsp beat with the dequeued
//   entry (zeros otherwise), a status and the occupancy after the operation.
//   Equal priorities are served newest first. An enqueue on a full queue is
//   dropped with a full status; a dequeue on an empty one returns an empty
//   status.
// Sequencing:
//   one request is worked on at a time; req.ready is high only when idle.
//   A dequeue reads the head entry, then takes it out. An enqueue passes
//   stored entries from the tail until it has passed them all or stops at
//   a higher-priority one, which costs one more read and compare, and then
//   inserts. Each pass is one RAM read and one compare-and-move through
//   the shared step unit. Full or empty rejects go straight to the response.
// Reset: rst clears the occupancy and the ring pointers; RAM contents are
//   not cleared and no clearing pass is needed.
// Backpressure: the response waits in an output register while rsp.ready is
//   low; the next request is accepted meanwhile and holds in its last step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int PRIO_BITS    = 4
) (
  input wire logic  clk,
  input wire logic  rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  import spq_pkg::*;

  `include "assert_macros.svh"

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = PAYLOAD_BITS + PRIO_BITS;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERD  = 3'd1;
  localparam logic [2:0] ST_ECMP = 3'd2;
  localparam logic [2:0] ST_EINS = 3'd3;
  localparam logic [2:0] ST_DRD  = 3'd4;
  localparam logic [2:0] ST_DOUT = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]              state;
  logic [CNT_W-1:0]        count;
  logic [PTR_W-1:0]        head;
  logic [PTR_W-1:0]        tail;
  logic [PTR_W-1:0]        cur;
  logic [CNT_W-1:0]        steps;
  logic                    op;
  logic [PAYLOAD_BITS-1:0] new_payload;
  logic [PRIO_BITS-1:0]    new_prio;
  logic [PAYLOAD_BITS-1:0] res_payload;
  logic [PRIO_BITS-1:0]    res_prio;
  status_t                 res_status;

  logic                    rsp_valid;
  logic [PAYLOAD_BITS-1:0] rsp_payload;
  logic [PRIO_BITS-1:0]    rsp_prio;
  status_t                 rsp_status;
  logic [CNT_W-1:0]        rsp_occupancy;

  logic                    ram_we;
  logic [PTR_W-1:0]        ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [PTR_W-1:0]        ram_raddr;
  logic [WORD_W-1:0]       ram_rdata;

  logic [PTR_W-1:0]        fwd_ptr;
  logic [PTR_W-1:0]        prev_ptr;
  logic [PTR_W-1:0]        next_ptr;
  logic                    moves;
  logic                    req_beat;
  logic                    rsp_free;

  assign req_beat = req.valid && req.ready;
  assign rsp_free = !rsp_valid || rsp.ready;

  // entry store
  spq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare and pointer step
  assign fwd_ptr = (op == OP_DEQ) ? head : tail;

  spq_step_unit #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS)
  ) u_step (
    .back_ptr  (cur),
    .fwd_ptr   (fwd_ptr),
    .held_prio (ram_rdata[PRIO_BITS-1:0]),
    .new_prio  (new_prio),
    .prev_ptr  (prev_ptr),
    .next_ptr  (next_ptr),
    .moves     (moves)
  );

  // ram port control
  always_comb begin
    ram_raddr = (state == ST_ERD) ? prev_ptr : head;
    ram_waddr = cur;
    ram_we    = 1'b0;
    ram_wdata = {new_payload, new_prio};
    if (state == ST_ECMP && moves) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (state == ST_EINS) begin
      ram_we    = 1'b1;
    end
  end

  // request handshake
  assign req.ready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_beat) begin
            op          <= req.opcode;
            new_payload <= req.payload;
            new_prio    <= req.prio;
            res_payload <= '0;
            res_prio    <= '0;
            res_status  <= STATUS_OK;
            cur         <= tail;
            steps       <= count;
            if (req.opcode == OP_ENQ) begin
              if (count == FULL_CNT) begin
                res_status <= STATUS_FULL;
                state      <= ST_FIN;
              end else if (count == '0) begin
                state <= ST_EINS;
              end else begin
                state <= ST_ERD;
              end
            end else begin
              if (count == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= ST_FIN;
              end else begin
                state <= ST_DRD;
              end
            end
          end
        end
        ST_ERD: begin
          state <= ST_ECMP;
        end
        ST_ECMP: begin
          if (moves) begin
            cur   <= prev_ptr;
            steps <= steps - CNT_W'(1);
            state <= (steps == CNT_W'(1)) ? ST_EINS : ST_ERD;
          end else begin
            state <= ST_EINS;
          end
        end
        ST_EINS: begin
          tail  <= next_ptr;
          count <= count + CNT_W'(1);
          state <= ST_FIN;
        end
        ST_DRD: begin
          state <= ST_DOUT;
        end
        ST_DOUT: begin
          res_payload <= ram_rdata[WORD_W-1:PRIO_BITS];
          res_prio    <= ram_rdata[PRIO_BITS-1:0];
          head        <= next_ptr;
          count       <= count - CNT_W'(1);
          state       <= ST_FIN;
        end
        ST_FIN: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_FIN && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && rsp_free) begin
      rsp_payload   <= res_payload;
      rsp_prio      <= res_prio;
      rsp_status    <= res_status;
      rsp_occupancy <= count;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.out_payload = rsp_payload;
  assign rsp.out_prio    = rsp_prio;
  assign rsp.status      = rsp_status;
  assign rsp.occupancy   = rsp_occupancy;

  // checks
  `SPQ_ASSERT(a_count_bound, clk, rst, count <= FULL_CNT)
  `SPQ_ASSERT(a_ring_ends, clk, rst, (count == '0 || count == FULL_CNT) -> (head == tail))
  `SPQ_ASSERT_NEXT(a_deq_shrinks, clk, rst, state == ST_DOUT, count == $past(count) - CNT_W'(1))
  `SPQ_ASSERT(a_rsp_from_fin, clk, rst, $rose(rsp_valid) -> ($past(state) == ST_FIN))

endmodule

`default_nettype wire
